/* rtl/core/chr_pkg.sv */
// ----------------------------------------------------------------------------
// Consistent hash ring package
// Shared types, constants and the one-at-a-time hash steps.
// ----------------------------------------------------------------------------
package chr_pkg;

   localparam int MaxReplicas  = 16;
   localparam int MaxNameBytes = 32;
   localparam int RingDepth    = 256;
   localparam int RingIdxW     = $clog2(RingDepth);
   localparam int RingCntW     = $clog2(RingDepth + 1);
   localparam int NameLenW     = $clog2(MaxNameBytes + 2);
   localparam int RepW         = $clog2(MaxReplicas + 1);

   localparam logic [1:0] OP_ADD    = 2'd0;
   localparam logic [1:0] OP_REMOVE = 2'd1;
   localparam logic [1:0] OP_LOOKUP = 2'd2;
   localparam logic [1:0] OP_NONE   = 2'd3;

   localparam logic [1:0] ST_OK    = 2'd0;
   localparam logic [1:0] ST_LONG  = 2'd1;
   localparam logic [1:0] ST_FULL  = 2'd2;
   localparam logic [1:0] ST_EMPTY = 2'd3;

   localparam logic [7:0] CharHash = 8'h23;
   localparam logic [7:0] CharZero = 8'h30;

   typedef struct packed {
      logic [1:0] operation;
      logic [7:0] data_byte;
      logic       last;
      logic [3:0] node_id;
   } req_type;

   typedef struct packed {
      logic [1:0]  status;
      logic [3:0]  found_node;
      logic [31:0] key_hash;
   } rsp_type;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic               absorb;      // mix an input byte into the prefix
      logic               latch_key;   // capture prefix, key hash, length flag
      logic               seed_rep;    // start replica hash from prefix
      logic               mix_char;    // mix one replica character
      logic [7:0]         mix_val;
      logic               fin_rep;     // finalise replica hash into target
      logic               use_key;     // target is the key hash
      logic               srch_step;   // register a compare result
      logic [RingIdxW-1:0] rd_addr;
      logic               rd_en;
      logic               wr_en;
      logic [RingIdxW-1:0] wr_addr;
      logic               wr_from_rd;  // write the registered read data
      logic [3:0]         wr_owner;
      logic               owner_only;  // keep point, rewrite owner
   } chr_cmd_type;

   // Status from the datapath.
   typedef struct packed {
      logic              too_long;
      logic              less;      // read point is below target
      logic              equal;     // read point equals target
      logic [31:0]       key_hash;
      logic [3:0]        rd_owner;
   } chr_sts_type;

   function automatic logic [31:0] oaat_mix(input logic [31:0] h, input logic [7:0] b);
      logic [31:0] t;
      t = h + {24'd0, b};
      t = t + (t << 10);
      t = t ^ (t >> 6);
      return t;
   endfunction

   function automatic logic [31:0] oaat_final(input logic [31:0] h);
      logic [31:0] t;
      t = h + (h << 3);
      t = t ^ (t >> 11);
      t = t + (t << 15);
      return t;
   endfunction

endpackage

/* rtl/core/chr_ram.sv */
// ----------------------------------------------------------------------------
// Generic RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module chr_ram #(
   parameter int Width = 8,
   parameter int Depth = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(Depth)-1:0] wr_addr,
   input  logic [Width-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(Depth)-1:0] rd_addr,
   output logic [Width-1:0]         rd_data
);

   logic [Width-1:0] mem [Depth];
   logic [Width-1:0] rd_data_ff;

   // Storage write and registered read.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

/* rtl/core/chr_datapath.sv */
// ----------------------------------------------------------------------------
// Consistent hash ring datapath
// Hash registers, ring memory and the point comparator.
// ----------------------------------------------------------------------------
module chr_datapath
   import chr_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  req_type     req_data,
   input  chr_cmd_type cmd,
   output chr_sts_type sts
);

   logic [31:0]         run_ff, run_in;
   logic [NameLenW-1:0] len_ff, len_in;
   logic [31:0]         prefix_ff, key_ff, rep_ff, tgt_ff;
   logic                long_ff;
   logic [35:0]         rd_data, wr_data;
   logic                less_ff, equal_ff;

   // Running hash and length, cleared after every last byte.
   always_comb begin
      run_in = run_ff;
      len_in = len_ff;
      if (cmd.absorb) begin
         if (req_data.last) begin
            run_in = '0;
            len_in = '0;
         end else begin
            run_in = oaat_mix(run_ff, req_data.data_byte);
            if (len_ff <= NameLenW'(MaxNameBytes)) begin
               len_in = len_ff + 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff <= '0;
         len_ff <= '0;
      end else begin
         run_ff <= run_in;
         len_ff <= len_in;
      end
   end

   // Key capture, replica hash and search target.
   always_ff @(posedge clock) begin
      if (cmd.latch_key) begin
         prefix_ff <= oaat_mix(run_ff, req_data.data_byte);
         key_ff    <= oaat_final(oaat_mix(run_ff, req_data.data_byte));
         long_ff   <= len_ff >= NameLenW'(MaxNameBytes);
      end
      if (cmd.seed_rep) begin
         rep_ff <= oaat_mix(prefix_ff, CharHash);
      end else if (cmd.mix_char) begin
         rep_ff <= oaat_mix(rep_ff, cmd.mix_val);
      end
      if (cmd.fin_rep) begin
         tgt_ff <= oaat_final(rep_ff);
      end else if (cmd.use_key) begin
         tgt_ff <= key_ff;
      end
      if (cmd.srch_step) begin
         less_ff  <= rd_data[35:4] < tgt_ff;
         equal_ff <= rd_data[35:4] == tgt_ff;
      end
   end

   // Ring write data: a shifted entry, or a new or re-owned point.
   always_comb begin
      if (cmd.wr_from_rd) begin
         wr_data = rd_data;
      end else if (cmd.owner_only) begin
         wr_data = {tgt_ff, cmd.wr_owner};
      end else begin
         wr_data = {tgt_ff, cmd.wr_owner};
      end
   end

   chr_ram #(.Width(36), .Depth(RingDepth)) u_ring (
      .clock   (clock),
      .wr_en   (cmd.wr_en),
      .wr_addr (cmd.wr_addr),
      .wr_data (wr_data),
      .rd_en   (cmd.rd_en),
      .rd_addr (cmd.rd_addr),
      .rd_data (rd_data)
   );

   // The RAM holds its read data until the next read, so the owner of the
   // last probed entry is taken straight from it.
   assign sts.too_long = long_ff;
   assign sts.less     = less_ff;
   assign sts.equal    = equal_ff;
   assign sts.key_hash = key_ff;
   assign sts.rd_owner = rd_data[3:0];

endmodule

/* rtl/core/chr_ctrl.sv */
// ----------------------------------------------------------------------------
// Consistent hash ring controller
// Sequences replica hashing, binary search, insertion, erasure and lookup.
// ----------------------------------------------------------------------------
module chr_ctrl
   import chr_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  req_type     req_data,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output rsp_type     rsp_data,
   input  logic [4:0]  vnodes,
   output chr_cmd_type cmd,
   input  chr_sts_type sts
);

   typedef enum logic [13:0] {
      S_IDLE  = 14'b00000000000001,
      S_KEY   = 14'b00000000000010,
      S_DIG   = 14'b00000000000100,
      S_FIN   = 14'b00000000001000,
      S_SRCH  = 14'b00000000010000,
      S_SWAIT = 14'b00000000100000,
      S_SCMP  = 14'b00000001000000,
      S_DEC   = 14'b00000010000000,
      S_SHRD  = 14'b00000100000000,
      S_SHWR  = 14'b00001000000000,
      S_PUT   = 14'b00010000000000,
      S_LKRD  = 14'b00100000000000,
      S_LKOUT = 14'b01000000000000,
      S_RSP   = 14'b10000000000000
   } state_type;

   state_type            state_ff, state_in;
   logic [1:0]           op_ff, op_in;
   logic [3:0]           id_ff, id_in;
   logic [RepW-1:0]      rep_ff, rep_in, reps;
   logic [1:0]           dig_ff, dig_in;
   logic [RingCntW-1:0]  cnt_ff, cnt_in;
   logic [RingCntW-1:0]  lo_ff, lo_in, hi_ff, hi_in, mid, k_ff, k_in;
   logic [1:0]           st_ff, st_in;
   logic                 vld_ff, vld_in;
   rsp_type              out_ff, out_in;
   logic                 accept, slot_free;
   logic [3:0]           tens, ones;
   logic [RepW-1:0]      rep_m10;

   assign accept    = req_valid && !req_stall;
   assign slot_free = !vld_ff || !rsp_stall;
   assign req_stall = (state_ff != S_IDLE);
   assign reps      = (vnodes > 5'(MaxReplicas)) ? RepW'(MaxReplicas) : RepW'(vnodes);
   assign mid       = lo_ff + ((hi_ff - lo_ff) >> 1);

   // Decimal digits of the replica index (below one hundred).
   always_comb begin
      rep_m10 = rep_ff;
      tens    = '0;
      for (int d = 0; d < 9; d++) begin
         if (rep_m10 >= RepW'(10)) begin
            rep_m10 = rep_m10 - RepW'(10);
            tens    = tens + 4'd1;
         end
      end
      ones = rep_m10[3:0];
   end

   // Next state and datapath commands.
   always_comb begin
      state_in = state_ff;
      op_in = op_ff; id_in = id_ff; rep_in = rep_ff; dig_in = dig_ff;
      cnt_in = cnt_ff; lo_in = lo_ff; hi_in = hi_ff; k_in = k_ff; st_in = st_ff;
      vld_in = vld_ff && rsp_stall;
      out_in = out_ff;
      cmd = '0;
      cmd.rd_addr  = mid[RingIdxW-1:0];
      cmd.wr_addr  = k_ff[RingIdxW-1:0];
      cmd.wr_owner = id_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (accept) begin
               cmd.absorb = 1'b1;
               if (req_data.last) begin
                  cmd.latch_key = 1'b1;
                  op_in = req_data.operation;
                  id_in = req_data.node_id;
                  rep_in = '0;
                  st_in = ST_OK;
                  if (req_data.operation != OP_NONE) begin
                     state_in = S_KEY;
                  end
               end
            end
         end
         S_KEY: begin
            if (op_ff == OP_LOOKUP) begin
               if (cnt_ff == '0) begin
                  st_in = ST_EMPTY;
                  state_in = S_RSP;
               end else begin
                  cmd.use_key = 1'b1;
                  state_in = S_SRCH;
               end
            end else if (sts.too_long) begin
               st_in = ST_LONG;
               state_in = S_RSP;
            end else if (rep_ff >= reps) begin
               state_in = S_RSP;
            end else begin
               cmd.seed_rep = 1'b1;
               dig_in = (rep_ff >= RepW'(10)) ? 2'd0 : 2'd1;
               state_in = S_DIG;
            end
         end
         S_DIG: begin
            cmd.mix_char = 1'b1;
            cmd.mix_val  = CharZero + ((dig_ff == 2'd0) ? {4'd0, tens} : {4'd0, ones});
            dig_in = dig_ff + 2'd1;
            if (dig_ff == 2'd1) begin
               state_in = S_FIN;
            end
         end
         S_FIN: begin
            cmd.fin_rep = 1'b1;
            state_in = S_SRCH;
         end
         S_SRCH: begin
            lo_in = '0;
            hi_in = cnt_ff;
            state_in = S_SWAIT;
         end
         S_SWAIT: begin
            if (lo_ff < hi_ff) begin
               cmd.rd_en = 1'b1;
               state_in = S_SCMP;
            end else begin
               state_in = S_DEC;
            end
         end
         S_SCMP: begin
            cmd.srch_step = 1'b1;
            state_in = S_SHRD;
            k_in = mid;
         end
         S_SHRD: begin
            // Apply the registered compare of the probed point.
            if (sts.less) begin
               lo_in = k_ff + 1'b1;
            end else begin
               hi_in = k_ff;
               if (sts.equal) begin
                  lo_in = k_ff;
                  hi_in = k_ff;
                  cnt_in = cnt_ff;
               end
            end
            state_in = S_SWAIT;
            if (!sts.less && sts.equal) begin
               state_in = S_DEC;
               lo_in = k_ff;
               hi_in = k_ff + 1'b1;
            end
         end
         S_DEC: begin
            // lo is the lower bound; hi = lo + 1 flags an exact match.
            if (op_ff == OP_LOOKUP) begin
               k_in = (lo_ff >= cnt_ff) ? '0 : lo_ff;
               state_in = S_LKRD;
            end else if (op_ff == OP_ADD) begin
               if (hi_ff == lo_ff + 1'b1 && lo_ff < cnt_ff) begin
                  cmd.wr_en = 1'b1;
                  cmd.wr_addr = lo_ff[RingIdxW-1:0];
                  cmd.owner_only = 1'b1;
                  state_in = S_PUT;
                  k_in = '1;
               end else if (cnt_ff >= RingCntW'(RingDepth)) begin
                  st_in = ST_FULL;
                  state_in = S_PUT;
                  k_in = '1;
               end else begin
                  k_in = cnt_ff;
                  state_in = S_SHWR;
               end
            end else begin
               if (hi_ff == lo_ff + 1'b1 && lo_ff < cnt_ff) begin
                  k_in = lo_ff;
                  state_in = S_SHWR;
               end else begin
                  state_in = S_PUT;
                  k_in = '1;
               end
            end
         end
         S_SHWR: begin
            // Shift one entry at a time: read here, write in S_LKOUT.
            if (op_ff == OP_ADD) begin
               if (k_ff > lo_ff) begin
                  cmd.rd_en = 1'b1;
                  cmd.rd_addr = RingIdxW'(k_ff - 1'b1);
                  state_in = S_LKOUT;
               end else begin
                  cmd.wr_en = 1'b1;
                  cmd.wr_addr = lo_ff[RingIdxW-1:0];
                  cnt_in = cnt_ff + 1'b1;
                  state_in = S_PUT;
                  k_in = '1;
               end
            end else begin
               if (k_ff + 1'b1 < cnt_ff) begin
                  cmd.rd_en = 1'b1;
                  cmd.rd_addr = RingIdxW'(k_ff + 1'b1);
                  state_in = S_LKOUT;
               end else begin
                  cnt_in = cnt_ff - 1'b1;
                  state_in = S_PUT;
                  k_in = '1;
               end
            end
         end
         S_PUT: begin
            rep_in = rep_ff + 1'b1;
            state_in = S_KEY;
         end
         S_LKRD: begin
            cmd.rd_en = 1'b1;
            cmd.rd_addr = k_ff[RingIdxW-1:0];
            state_in = S_LKOUT;
         end
         S_LKOUT: begin
            if (op_ff == OP_LOOKUP) begin
               state_in = S_RSP;
            end else begin
               cmd.wr_en = 1'b1;
               cmd.wr_from_rd = 1'b1;
               cmd.wr_addr = k_ff[RingIdxW-1:0];
               k_in = (op_ff == OP_ADD) ? k_ff - 1'b1 : k_ff + 1'b1;
               state_in = S_SHWR;
            end
         end
         S_RSP: begin
            if (slot_free) begin
               vld_in = 1'b1;
               out_in.status = st_ff;
               out_in.key_hash = sts.key_hash;
               out_in.found_node = (op_ff == OP_LOOKUP && st_ff == ST_OK) ?
                                   sts.rd_owner : 4'd0;
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         cnt_ff   <= '0;
         vld_ff   <= 1'b0;
      end else begin
         state_ff <= state_in;
         cnt_ff   <= cnt_in;
         vld_ff   <= vld_in;
      end
      op_ff <= op_in; id_ff <= id_in; rep_ff <= rep_in; dig_ff <= dig_in;
      lo_ff <= lo_in; hi_ff <= hi_in; k_ff <= k_in; st_ff <= st_in;
      out_ff <= out_in;
   end

   assign rsp_valid = vld_ff;
   assign rsp_data  = out_ff;

   a_count_range: assert property (@(posedge clock) disable iff (reset)
      cnt_ff <= RingCntW'(RingDepth)) else $error("ring count overflow");
   a_count_step: assert property (@(posedge clock) disable iff (reset)
      (cnt_ff != $past(cnt_ff)) |-> (state_ff == S_PUT)) else $error("count moved");
   a_idle_only: assert property (@(posedge clock) disable iff (reset)
      !req_stall |-> state_ff == S_IDLE) else $error("accept outside idle");

endmodule

/* rtl/core/consistent_hash_ring_top.sv */
// ----------------------------------------------------------------------------
// Consistent hash ring top level
// Jenkins one-at-a-time hashed ring with add, remove and lookup.
// ----------------------------------------------------------------------------
//  Channel   Direction  Payload
//  req_      in         operation, data_byte, last, node_id
//  rsp_      out        status, found_node, key_hash
//  csr_      in/out     virtual_nodes at byte address 0
//
//  Non-final bytes are taken while the ring is idle; the last byte of an add,
//  remove or lookup stalls requests until its result is issued. A lookup
//  makes at most log2(count) + 1 search probes, fewer on an exact hit, and
//  answers an empty ring without a search. An add or remove walks each
//  replica through hashing, a binary search in the ring memory and a shift
//  of up to count entries, all through the one ring memory. Reset is synchronous
//  and empties the ring at once. A stalled result holds in the output register.
// ----------------------------------------------------------------------------
module consistent_hash_ring_top
   import chr_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  req_type     req_data,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output rsp_type     rsp_data,
   input  logic        psel,
   input  logic        penable,
   input  logic        pwrite,
   input  logic        paddr,
   input  logic [31:0] pwdata,
   output logic [31:0] prdata,
   output logic        pready
);

   logic [4:0]  vnodes_ff;
   chr_cmd_type cmd;
   chr_sts_type sts;

   // Configuration register.
   always_ff @(posedge clock) begin
      if (reset) begin
         vnodes_ff <= 5'd16;
      end else if (psel && penable && pwrite && !paddr) begin
         vnodes_ff <= pwdata[4:0];
      end
   end

   assign pready = 1'b1;
   assign prdata = paddr ? 32'd0 : {27'd0, vnodes_ff};

   chr_ctrl u_ctrl (
      .clock, .reset, .req_valid, .req_stall, .req_data,
      .rsp_valid, .rsp_stall, .rsp_data,
      .vnodes (vnodes_ff), .cmd, .sts
   );

   chr_datapath u_dp (
      .clock, .reset, .req_data, .cmd, .sts
   );

endmodule
